FILE: rtl/core/tcg_pkg.sv
// Shared types and constants of the text console grid.
// Used by every module of the console; no dependencies.
package tcg_pkg;

  // Operation codes of an input word
  localparam logic [2:0] OP_PUT   = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_VIEW  = 3'd2;
  localparam logic [2:0] OP_MOVE  = 3'd3;
  localparam logic [2:0] OP_ERASE = 3'd4;
  localparam logic [2:0] OP_CLEAR = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] REG_COLS = 3'd0;
  localparam logic [2:0] REG_ROWS = 3'd1;
  localparam logic [2:0] REG_FG   = 3'd2;
  localparam logic [2:0] REG_BG   = 3'd3;

  localparam logic [15:0] BLANK_CHAR = 16'h0020;
  localparam logic [15:0] QMARK_CHAR = 16'h003F;
  localparam logic [7:0]  BASE_ATTR  = 8'h70;
  localparam logic [23:0] CELL_BLANK = {BLANK_CHAR, BASE_ATTR};

  // Classified command handed from front to back
  typedef enum logic [3:0] {
    C_NOP, C_CHAR, C_LF, C_CR, C_BS, C_TAB, C_READ, C_VIEW, C_MOVE, C_ERASE, C_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [15:0]        cp;
    logic [5:0]         row;
    logic [6:0]         col;
    logic signed [10:0] delta;
  } cmd_t;

  // Geometry and colour seen by the back end
  typedef struct packed {
    logic [7:0] cols;
    logic [6:0] rows;
    logic [7:0] attr;
    logic       clamp;
  } geom_t;

  typedef struct packed {
    logic [15:0] chr;
    logic [7:0]  attr;
    logic [5:0]  row;
    logic [6:0]  col;
    logic [8:0]  view;
  } result_t;

endpackage

FILE: rtl/core/tcg_front.sv
// Front end: UTF-8 assembly and classification of input words into commands.
// Depends on tcg_pkg.
module tcg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc_i,
  input  logic [2:0]          operation_i,
  input  logic [7:0]          text_byte_i,
  input  logic [5:0]          row_index_i,
  input  logic [6:0]          column_index_i,
  input  logic signed [10:0]  view_delta_i,
  output tcg_pkg::cmd_t       cmd_o
);

  logic [31:0] pend_r, pend_nxt;
  logic [2:0]  pcnt_r, pcnt_nxt;
  logic [7:0]  lead;
  logic [2:0]  need;
  logic [20:0] cp21;
  logic        fresh;

  // Assemble sequences and classify the word
  always_comb begin
    pend_nxt    = pend_r;
    pcnt_nxt    = pcnt_r;
    fresh       = 1'b0;
    lead        = 8'h00;
    need        = 3'd4;
    cp21        = '0;
    cmd_o.kind  = tcg_pkg::C_NOP;
    cmd_o.cp    = {8'h00, text_byte_i};
    cmd_o.row   = row_index_i;
    cmd_o.col   = column_index_i;
    cmd_o.delta = view_delta_i;
    unique case (operation_i)
      tcg_pkg::OP_PUT: begin
        fresh = 1'b1;
        if (pcnt_r != 3'd0) begin
          if (text_byte_i[7:6] == 2'b10) begin
            fresh = 1'b0;
            if (pcnt_r < 3'd4) begin
              pend_nxt = pend_r | (32'(text_byte_i) << {pcnt_r[1:0], 3'b000});
              pcnt_nxt = pcnt_r + 3'd1;
            end
            lead = pend_nxt[7:0];
            if (lead[7:5] == 3'b110) need = 3'd2;
            else if (lead[7:4] == 4'b1110) need = 3'd3;
            else need = 3'd4;
            if (pcnt_nxt >= need) begin
              if (need == 3'd2) cp21 = {10'd0, lead[4:0], pend_nxt[13:8]};
              else if (need == 3'd3)
                cp21 = {5'd0, lead[3:0], pend_nxt[13:8], pend_nxt[21:16]};
              else cp21 = {lead[2:0], pend_nxt[13:8], pend_nxt[21:16], pend_nxt[29:24]};
              pend_nxt   = '0;
              pcnt_nxt   = 3'd0;
              cmd_o.kind = tcg_pkg::C_CHAR;
              cmd_o.cp   = (cp21[20:16] != 5'd0) ? tcg_pkg::QMARK_CHAR : cp21[15:0];
            end
          end else begin
            pend_nxt = '0;
            pcnt_nxt = 3'd0;
          end
        end
        if (fresh) begin
          if (text_byte_i[7]) begin
            if (text_byte_i[6]) begin
              pend_nxt = 32'(text_byte_i);
              pcnt_nxt = 3'd1;
            end
          end else if (text_byte_i == 8'h0A) cmd_o.kind = tcg_pkg::C_LF;
          else if (text_byte_i == 8'h0D) cmd_o.kind = tcg_pkg::C_CR;
          else if (text_byte_i == 8'h08) cmd_o.kind = tcg_pkg::C_BS;
          else if (text_byte_i == 8'h09) cmd_o.kind = tcg_pkg::C_TAB;
          else cmd_o.kind = tcg_pkg::C_CHAR;
        end
      end
      tcg_pkg::OP_READ:  cmd_o.kind = tcg_pkg::C_READ;
      tcg_pkg::OP_VIEW:  cmd_o.kind = tcg_pkg::C_VIEW;
      tcg_pkg::OP_MOVE:  cmd_o.kind = tcg_pkg::C_MOVE;
      tcg_pkg::OP_ERASE: cmd_o.kind = tcg_pkg::C_ERASE;
      tcg_pkg::OP_CLEAR: cmd_o.kind = tcg_pkg::C_CLEAR;
      default:           cmd_o.kind = tcg_pkg::C_NOP;
    endcase
  end

  // Hold the pending sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      pcnt_r <= 3'd0;
    end else if (acc_i) begin
      pend_r <= pend_nxt;
      pcnt_r <= pcnt_nxt;
    end
  end

endmodule

FILE: rtl/core/tcg_queue.sv
// Two-entry command queue between front and back end.
// Depends on tcg_pkg.
module tcg_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  tcg_pkg::cmd_t data_i,
  input  logic          pop_i,
  output tcg_pkg::cmd_t data_o,
  output logic          vld_o,
  output logic          full_o
);

  tcg_pkg::cmd_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign data_o = mem_r[rp_r];
  assign vld_o  = (cnt_r != 2'd0);
  assign full_o = (cnt_r == 2'd2);

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push_i) mem_r[wp_r] <= data_i;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_i) wp_r <= ~wp_r;
      if (pop_i)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

FILE: rtl/core/tcg_back.sv
// Back end: sequencer over the grid and history memories, cursor and view state.
// Depends on tcg_pkg.
module tcg_back #(
  parameter int MC = 128,
  parameter int MR = 64,
  parameter int HL = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tcg_pkg::cmd_t    cmd_i,
  input  logic             cmd_vld_i,
  output logic             cmd_pop_o,
  input  tcg_pkg::geom_t   geom_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output tcg_pkg::result_t res_o,
  output logic             init_busy_o
);

  localparam int GAW = (MR * MC > 1) ? $clog2(MR * MC) : 1;
  localparam int HAW = (HL * MC > 1) ? $clog2(HL * MC) : 1;
  localparam int CIW = (MC > 1) ? $clog2(MC) : 1;
  localparam int HHW = (HL > 1) ? $clog2(HL) : 1;
  localparam int VW  = $clog2(HL + 1);

  typedef enum logic [12:0] {
    S_INIT   = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_DISP   = 13'b0000000000100,
    S_WCHAR  = 13'b0000000001000,
    S_LF     = 13'b0000000010000,
    S_HIST   = 13'b0000000100000,
    S_SHIFT  = 13'b0000001000000,
    S_BLANK  = 13'b0000010000000,
    S_ERASE  = 13'b0000100000000,
    S_CLEAR  = 13'b0001000000000,
    S_RDISS  = 13'b0010000000000,
    S_RDWAIT = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  state_t              state_r, state_nxt;
  tcg_pkg::cmd_t       cmd_r, cmd_nxt;
  logic [5:0]          row_r, row_nxt;
  logic [6:0]          col_r, col_nxt;
  logic [HHW-1:0]      head_r, head_nxt;
  logic [VW-1:0]       count_r, count_nxt;
  logic [VW-1:0]       view_r, view_nxt;
  logic [1:0]          tab_r, tab_nxt;
  logic [15:0]         ch_r, ch_nxt;
  logic [CIW-1:0]      c_r, c_nxt;
  logic [6:0]          r_r, r_nxt;
  logic [GAW-1:0]      sw_r, sw_nxt;
  logic signed [11:0]  v_r, v_nxt;
  logic                rd_hist_r, rd_hist_nxt;
  logic                rd_blank_r, rd_blank_nxt;
  logic [15:0]         rchr_r, rchr_nxt;
  logic [7:0]          rattr_r, rattr_nxt;
  logic                out_vld_r, out_vld_nxt;
  tcg_pkg::result_t    out_res_r, out_res_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic                pend_hist_r, pend_hist_nxt;
  logic                pend_use_rd_r, pend_use_rd_nxt;
  logic [GAW-1:0]      pend_gaddr_r, pend_gaddr_nxt;
  logic [HAW-1:0]      pend_haddr_r, pend_haddr_nxt;
  logic [23:0]         pend_word_r, pend_word_nxt;

  logic [23:0]         gmem [MR*MC];
  logic [23:0]         hmem [HL*MC];
  logic [23:0]         grid_rd_r, hist_rd_r, wword;
  logic [GAW-1:0]      graddr;
  logic [HAW-1:0]      hraddr;

  logic                last_col;
  logic signed [12:0]  vsum;
  logic                hist_hit, grid_hit, col_ok;
  logic [11:0]         ri_sum, ri, lr;

  function automatic logic [GAW-1:0] gidx(input logic [6:0] r, input logic [7:0] c);
    gidx = GAW'(32'(r) * MC + 32'(c));
  endfunction

  assign last_col    = (9'(c_r) + 9'd1 >= 9'(geom_i.cols));
  assign wword       = pend_use_rd_r ? grid_rd_r : pend_word_r;
  assign out_valid_o = out_vld_r;
  assign res_o       = out_res_r;
  assign init_busy_o = (state_r == S_INIT);

  // Sequence the commands
  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    row_nxt         = row_r;
    col_nxt         = col_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    view_nxt        = view_r;
    tab_nxt         = tab_r;
    ch_nxt          = ch_r;
    c_nxt           = c_r;
    r_nxt           = r_r;
    sw_nxt          = sw_r;
    v_nxt           = v_r;
    rd_hist_nxt     = rd_hist_r;
    rd_blank_nxt    = rd_blank_r;
    rchr_nxt        = rchr_r;
    rattr_nxt       = rattr_r;
    out_res_nxt     = out_res_r;
    out_vld_nxt     = out_vld_r & out_stall_i;
    pend_vld_nxt    = 1'b0;
    pend_hist_nxt   = 1'b0;
    pend_use_rd_nxt = 1'b0;
    pend_gaddr_nxt  = pend_gaddr_r;
    pend_haddr_nxt  = pend_haddr_r;
    pend_word_nxt   = tcg_pkg::CELL_BLANK;
    graddr          = '0;
    hraddr          = '0;
    cmd_pop_o       = 1'b0;
    vsum            = '0;
    hist_hit        = 1'b0;
    grid_hit        = 1'b0;
    col_ok          = 1'b0;
    ri_sum          = '0;
    ri              = '0;
    lr              = '0;
    unique case (state_r)
      S_INIT, S_CLEAR: begin
        pend_vld_nxt   = 1'b1;
        pend_gaddr_nxt = sw_r;
        sw_nxt         = sw_r + GAW'(1);
        if (sw_r == GAW'(MR * MC - 1)) begin
          sw_nxt    = '0;
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (geom_i.clamp) begin
          if ({1'b0, col_r} >= geom_i.cols) col_nxt = 7'(geom_i.cols - 8'd1);
          if ({1'b0, row_r} >= geom_i.rows) row_nxt = 6'(geom_i.rows - 7'd1);
        end else if (cmd_vld_i) begin
          cmd_pop_o = 1'b1;
          cmd_nxt   = cmd_i;
          rchr_nxt  = 16'h0000;
          rattr_nxt = 8'h00;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (cmd_r.kind)
          tcg_pkg::C_CHAR: begin
            ch_nxt    = cmd_r.cp;
            tab_nxt   = 2'd0;
            state_nxt = S_WCHAR;
          end
          tcg_pkg::C_TAB: begin
            ch_nxt    = tcg_pkg::BLANK_CHAR;
            tab_nxt   = 2'd3;
            state_nxt = S_WCHAR;
          end
          tcg_pkg::C_LF: begin
            tab_nxt   = 2'd0;
            state_nxt = S_LF;
          end
          tcg_pkg::C_CR: begin
            col_nxt   = 7'd0;
            state_nxt = S_DONE;
          end
          tcg_pkg::C_BS: begin
            if (col_r != 7'd0) begin
              col_nxt        = col_r - 7'd1;
              pend_vld_nxt   = 1'b1;
              pend_gaddr_nxt = gidx({1'b0, row_r}, {1'b0, col_r - 7'd1});
              pend_word_nxt  = {tcg_pkg::BLANK_CHAR, geom_i.attr};
            end
            state_nxt = S_DONE;
          end
          tcg_pkg::C_READ: begin
            v_nxt     = 12'(count_r) - 12'(view_r) + 12'(cmd_r.row);
            state_nxt = S_RDISS;
          end
          tcg_pkg::C_VIEW: begin
            vsum = 13'(view_r) + 13'(cmd_r.delta);
            if (vsum < 0) view_nxt = '0;
            else if (vsum > 13'(count_r)) view_nxt = count_r;
            else view_nxt = VW'(vsum);
            state_nxt = S_DONE;
          end
          tcg_pkg::C_MOVE: begin
            row_nxt   = ({1'b0, cmd_r.row} >= geom_i.rows) ? 6'(geom_i.rows - 7'd1) : cmd_r.row;
            col_nxt   = ({1'b0, cmd_r.col} >= geom_i.cols) ? 7'(geom_i.cols - 8'd1) : cmd_r.col;
            state_nxt = S_DONE;
          end
          tcg_pkg::C_ERASE: begin
            c_nxt     = CIW'(col_r);
            state_nxt = ({1'b0, col_r} < geom_i.cols) ? S_ERASE : S_DONE;
          end
          tcg_pkg::C_CLEAR: begin
            row_nxt   = 6'd0;
            col_nxt   = 7'd0;
            view_nxt  = '0;
            sw_nxt    = '0;
            state_nxt = S_CLEAR;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_WCHAR: begin
        pend_vld_nxt   = 1'b1;
        pend_gaddr_nxt = gidx({1'b0, row_r}, {1'b0, col_r});
        pend_word_nxt  = {ch_r, geom_i.attr};
        if ({1'b0, col_r} + 8'd1 >= geom_i.cols) begin
          col_nxt   = 7'd0;
          state_nxt = S_LF;
        end else begin
          col_nxt = col_r + 7'd1;
          if (tab_r != 2'd0) tab_nxt = tab_r - 2'd1;
          else state_nxt = S_DONE;
        end
      end
      S_LF: begin
        col_nxt = 7'd0;
        if ({1'b0, row_r} + 7'd1 >= geom_i.rows) begin
          c_nxt     = '0;
          state_nxt = S_HIST;
        end else begin
          row_nxt = row_r + 6'd1;
          if (tab_r != 2'd0) begin
            tab_nxt   = tab_r - 2'd1;
            state_nxt = S_WCHAR;
          end else state_nxt = S_DONE;
        end
      end
      S_HIST: begin
        // copy the top row into the ring, blank past the visible columns
        graddr          = gidx(7'd0, 8'(c_r));
        pend_vld_nxt    = 1'b1;
        pend_hist_nxt   = 1'b1;
        pend_haddr_nxt  = HAW'(32'(head_r) * MC + 32'(c_r));
        pend_use_rd_nxt = (9'(c_r) < 9'(geom_i.cols));
        if (c_r == CIW'(MC - 1)) begin
          head_nxt  = (head_r == HHW'(HL - 1)) ? '0 : head_r + HHW'(1);
          if (count_r < VW'(HL)) count_nxt = count_r + VW'(1);
          c_nxt     = '0;
          r_nxt     = 7'd1;
          state_nxt = (geom_i.rows > 7'd1) ? S_SHIFT : S_BLANK;
        end else c_nxt = c_r + CIW'(1);
      end
      S_SHIFT: begin
        graddr          = gidx(r_r, 8'(c_r));
        pend_vld_nxt    = 1'b1;
        pend_use_rd_nxt = 1'b1;
        pend_gaddr_nxt  = gidx(r_r - 7'd1, 8'(c_r));
        if (last_col) begin
          c_nxt = '0;
          if (r_r + 7'd1 >= geom_i.rows) state_nxt = S_BLANK;
          else r_nxt = r_r + 7'd1;
        end else c_nxt = c_r + CIW'(1);
      end
      S_BLANK: begin
        pend_vld_nxt   = 1'b1;
        pend_gaddr_nxt = gidx(geom_i.rows - 7'd1, 8'(c_r));
        if (last_col) begin
          c_nxt = '0;
          if (view_r != '0 && view_r < count_r) view_nxt = view_r + VW'(1);
          if (tab_r != 2'd0) begin
            tab_nxt   = tab_r - 2'd1;
            state_nxt = S_WCHAR;
          end else state_nxt = S_DONE;
        end else c_nxt = c_r + CIW'(1);
      end
      S_ERASE: begin
        pend_vld_nxt   = 1'b1;
        pend_gaddr_nxt = gidx({1'b0, row_r}, 8'(c_r));
        pend_word_nxt  = {tcg_pkg::BLANK_CHAR, geom_i.attr};
        if (last_col) state_nxt = S_DONE;
        else c_nxt = c_r + CIW'(1);
      end
      S_RDISS: begin
        // map the viewport row onto history or live rows
        hist_hit     = (v_r >= 0) && (v_r < $signed(12'(count_r)));
        ri_sum       = 12'(head_r) + 12'(HL) - 12'(count_r) + v_r;
        ri           = (ri_sum >= 12'(HL)) ? ri_sum - 12'(HL) : ri_sum;
        lr           = v_r - 12'(count_r);
        grid_hit     = !hist_hit && (v_r >= 0) && (lr < 12'(geom_i.rows));
        col_ok       = (9'(cmd_r.col) < 9'(MC));
        hraddr       = HAW'(32'(ri) * MC + 32'(cmd_r.col));
        graddr       = gidx(lr[6:0], {1'b0, cmd_r.col});
        rd_hist_nxt  = hist_hit;
        rd_blank_nxt = !col_ok || (!hist_hit && !grid_hit);
        state_nxt    = S_RDWAIT;
      end
      S_RDWAIT: begin
        if (rd_blank_r) {rchr_nxt, rattr_nxt} = tcg_pkg::CELL_BLANK;
        else if (rd_hist_r) {rchr_nxt, rattr_nxt} = hist_rd_r;
        else {rchr_nxt, rattr_nxt} = grid_rd_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_r || !out_stall_i) begin
          out_vld_nxt      = 1'b1;
          out_res_nxt.chr  = rchr_r;
          out_res_nxt.attr = rattr_r;
          out_res_nxt.row  = row_r;
          out_res_nxt.col  = col_r;
          out_res_nxt.view = 9'(view_r);
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Update control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      row_r      <= 6'd0;
      col_r      <= 7'd0;
      head_r     <= '0;
      count_r    <= '0;
      view_r     <= '0;
      tab_r      <= 2'd0;
      sw_r       <= '0;
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      view_r     <= view_nxt;
      tab_r      <= tab_nxt;
      sw_r       <= sw_nxt;
      out_vld_r  <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    ch_r          <= ch_nxt;
    c_r           <= c_nxt;
    r_r           <= r_nxt;
    v_r           <= v_nxt;
    rd_hist_r     <= rd_hist_nxt;
    rd_blank_r    <= rd_blank_nxt;
    rchr_r        <= rchr_nxt;
    rattr_r       <= rattr_nxt;
    out_res_r     <= out_res_nxt;
    pend_hist_r   <= pend_hist_nxt;
    pend_use_rd_r <= pend_use_rd_nxt;
    pend_gaddr_r  <= pend_gaddr_nxt;
    pend_haddr_r  <= pend_haddr_nxt;
    pend_word_r   <= pend_word_nxt;
  end

  // Grid memory, read forwards the write of the same cycle
  always_ff @(posedge clk) begin
    if (pend_vld_r && !pend_hist_r) gmem[pend_gaddr_r] <= wword;
    if (pend_vld_r && !pend_hist_r && pend_gaddr_r == graddr) grid_rd_r <= wword;
    else grid_rd_r <= gmem[graddr];
  end

  // History memory
  always_ff @(posedge clk) begin
    if (pend_vld_r && pend_hist_r) hmem[pend_haddr_r] <= wword;
    hist_rd_r <= hmem[hraddr];
  end

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= VW'(HL))
    else $error("history count above ring depth");

  a_view_bound: assert property (@(posedge clk) disable iff (!rst_n)
    view_r <= count_r)
    else $error("view offset beyond history count");

  a_tab_live: assert property (@(posedge clk) disable iff (!rst_n)
    (tab_r != 2'd0) |-> (state_r == S_WCHAR || state_r == S_LF || state_r == S_HIST ||
                         state_r == S_SHIFT || state_r == S_BLANK))
    else $error("tab spaces left outside a write sequence");

endmodule

FILE: rtl/core/text_console_grid_with_scrollback.sv
// Text console grid with scrollback: top level, config registers; uses tcg_pkg, tcg_front,
// tcg_queue and tcg_back. A scroll copies the top row into the history ring, shifts the
// visible rows up and blanks the bottom row; clear blanks the whole grid memory.
// Throughput: one word at a time in the back end, which takes the next one from the queue
// once back in its idle state after loading a result. Reset: synchronous; grid blanking
// then stalls input.
module text_console_grid_with_scrollback #(
  parameter int MAX_COLUMNS   = 128,
  parameter int MAX_ROWS      = 64,
  parameter int HISTORY_LINES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_operation,
  input  logic [7:0]         in_text_byte,
  input  logic [5:0]         in_row_index,
  input  logic [6:0]         in_column_index,
  input  logic signed [10:0] in_view_delta,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_cell_char,
  output logic [7:0]         out_cell_attr,
  output logic [5:0]         out_cursor_row_now,
  output logic [6:0]         out_cursor_column_now,
  output logic [8:0]         out_view_offset_now,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_wdata
);

  logic [7:0]       cols_r;
  logic [6:0]       rows_r;
  logic [3:0]       fg_r, bg_r;
  logic             clamp_r;
  logic             cfg_wr, acc, q_full, q_vld, q_pop, init_busy;
  tcg_pkg::cmd_t    f_cmd, q_cmd;
  tcg_pkg::geom_t   geom;
  tcg_pkg::result_t res;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign in_stall  = q_full | init_busy;
  assign acc       = in_valid & ~in_stall;

  // Write configuration registers with clamping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= 8'((MAX_COLUMNS < 80) ? MAX_COLUMNS : 80);
      rows_r  <= 7'((MAX_ROWS < 25) ? MAX_ROWS : 25);
      fg_r    <= 4'd7;
      bg_r    <= 4'd0;
      clamp_r <= 1'b0;
    end else begin
      clamp_r <= 1'b0;
      if (cfg_wr) begin
        unique case (cfg_index)
          tcg_pkg::REG_COLS: begin
            if (9'(cfg_wdata) > 9'(MAX_COLUMNS)) cols_r <= 8'(MAX_COLUMNS);
            else if (cfg_wdata == 8'd0) cols_r <= 8'd1;
            else cols_r <= cfg_wdata;
            clamp_r <= 1'b1;
          end
          tcg_pkg::REG_ROWS: begin
            if (8'(cfg_wdata[6:0]) > 8'(MAX_ROWS)) rows_r <= 7'(MAX_ROWS);
            else if (cfg_wdata[6:0] == 7'd0) rows_r <= 7'd1;
            else rows_r <= cfg_wdata[6:0];
            clamp_r <= 1'b1;
          end
          tcg_pkg::REG_FG: fg_r <= cfg_wdata[3:0];
          tcg_pkg::REG_BG: bg_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
    end
  end

  assign geom.cols  = cols_r;
  assign geom.rows  = rows_r;
  assign geom.attr  = {fg_r, bg_r};
  assign geom.clamp = clamp_r;

  tcg_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc_i          (acc),
    .operation_i    (in_operation),
    .text_byte_i    (in_text_byte),
    .row_index_i    (in_row_index),
    .column_index_i (in_column_index),
    .view_delta_i   (in_view_delta),
    .cmd_o          (f_cmd)
  );

  tcg_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (acc),
    .data_i (f_cmd),
    .pop_i  (q_pop),
    .data_o (q_cmd),
    .vld_o  (q_vld),
    .full_o (q_full)
  );

  tcg_back #(
    .MC (MAX_COLUMNS),
    .MR (MAX_ROWS),
    .HL (HISTORY_LINES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (q_cmd),
    .cmd_vld_i   (q_vld),
    .cmd_pop_o   (q_pop),
    .geom_i      (geom),
    .out_stall_i (out_stall),
    .out_valid_o (out_valid),
    .res_o       (res),
    .init_busy_o (init_busy)
  );

  assign out_cell_char         = res.chr;
  assign out_cell_attr         = res.attr;
  assign out_cursor_row_now    = res.row;
  assign out_cursor_column_now = res.col;
  assign out_view_offset_now   = res.view;

endmodule
